>>> hdl/restoring_divider_31bit_defines.svh
// ----------------------------------------------------------------------------
// Restoring divider assertion macros
// Concurrent check helpers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RESTORING_DIVIDER_31BIT_DEFINES_SVH
`define RESTORING_DIVIDER_31BIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RDIV_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("divider check failed");
`define RDIV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("divider check failed");
`else
`define RDIV_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define RDIV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/rdiv31_pkg.sv
// ----------------------------------------------------------------------------
// Restoring divider package
// Fixed field widths and types shared by the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package rdiv31_pkg;

    localparam int DIVISOR_W = 31;

    typedef logic [DIVISOR_W-1:0] t_divisor;

endpackage

`default_nettype wire

>>> hdl/restoring_divider_31bit.sv
// ----------------------------------------------------------------------------
// Restoring divider, 31 quotient bits
// Pipelined unsigned restoring division with saturating quotient.
// ----------------------------------------------------------------------------
// One word enters per cycle while the output side is not stalled. An input
// register is followed by one stage per quotient bit, each doing a single
// shifted-divisor compare and subtract on the running remainder, most
// significant bit first, then an output register that forms the saturation
// flag (remainder not below divisor). Stages with no valid word fill in
// while a later stage is stalled. Input tdata: dividend, divisor.
// Output tdata: quotient, remainder, saturated. A zero divisor gives an
// all-ones quotient, the dividend as remainder, and saturated set.
// ----------------------------------------------------------------------------
`default_nettype none

`include "restoring_divider_31bit_defines.svh"

module restoring_divider_31bit #(
    parameter int QUOTIENT_BITS = 31,
    parameter int DIVIDEND_BITS = 62
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_axis_tvalid,
    output logic      o_s_axis_tready,
    // dividend, divisor
    input  wire logic [((DIVIDEND_BITS + rdiv31_pkg::DIVISOR_W + 7) / 8) * 8 - 1:0]
                      i_s_axis_tdata,
    output logic      o_m_axis_tvalid,
    input  wire logic i_m_axis_tready,
    // quotient, remainder, saturated
    output logic [((QUOTIENT_BITS + DIVIDEND_BITS + 1 + 7) / 8) * 8 - 1:0]
                      o_m_axis_tdata
);

    import rdiv31_pkg::*;

    localparam int OUT_W  = ((QUOTIENT_BITS + DIVIDEND_BITS + 1 + 7) / 8) * 8;
    localparam int TRY_W  = DIVISOR_W + QUOTIENT_BITS;
    localparam int CMP_W  = (TRY_W > DIVIDEND_BITS) ? TRY_W : DIVIDEND_BITS;
    localparam int SAT_W  = (DIVISOR_W > DIVIDEND_BITS) ? DIVISOR_W : DIVIDEND_BITS;
    localparam logic [QUOTIENT_BITS-1:0] QUO_ONES = {QUOTIENT_BITS{1'b1}};

    logic [DIVIDEND_BITS-1:0] r_rem [0:QUOTIENT_BITS];
    t_divisor                 r_den [0:QUOTIENT_BITS];
    logic [QUOTIENT_BITS-1:0] r_quo [0:QUOTIENT_BITS];
    logic [QUOTIENT_BITS:0]   r_vld;
    logic [QUOTIENT_BITS+1:0] w_en;

    logic [QUOTIENT_BITS-1:0] r_out_quo;
    logic [DIVIDEND_BITS-1:0] r_out_rem;
    logic                     r_out_sat;
    logic                     r_out_vld;
    logic                     n_out_sat;

    // Advance a stage when it is empty or the next one advances.
    assign w_en[QUOTIENT_BITS+1] = !r_out_vld || i_m_axis_tready;

    genvar g;
    generate
        for (g = 0; g <= QUOTIENT_BITS; g++) begin : g_en
            assign w_en[g] = !r_vld[g] || w_en[g+1];
        end
    endgenerate

    assign o_s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en[0]) begin
            r_vld[0] <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_rem[0] <= i_s_axis_tdata[DIVIDEND_BITS-1:0];
            r_den[0] <= i_s_axis_tdata[DIVIDEND_BITS +: DIVISOR_W];
            r_quo[0] <= '0;
        end
    end

    generate
        for (g = 1; g <= QUOTIENT_BITS; g++) begin : g_stage
            localparam int BIT = QUOTIENT_BITS - g;

            logic [CMP_W-1:0]         w_try;
            logic [CMP_W-1:0]         w_rem_x;
            logic                     w_fit;
            logic [DIVIDEND_BITS-1:0] n_rem;
            logic [QUOTIENT_BITS-1:0] n_quo;

            always_comb begin
                w_try   = CMP_W'(r_den[g-1]) << BIT;
                w_rem_x = CMP_W'(r_rem[g-1]);
                w_fit   = (w_try <= w_rem_x);
                n_rem   = r_rem[g-1];
                n_quo   = r_quo[g-1];
                if (w_fit) begin
                    n_rem      = r_rem[g-1] - w_try[DIVIDEND_BITS-1:0];
                    n_quo[BIT] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g] <= 1'b0;
                end else if (w_en[g]) begin
                    r_vld[g] <= r_vld[g-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en[g]) begin
                    r_rem[g] <= n_rem;
                    r_den[g] <= r_den[g-1];
                    r_quo[g] <= n_quo;
                end
            end
        end
    endgenerate

    assign n_out_sat = (SAT_W'(r_rem[QUOTIENT_BITS]) >= SAT_W'(r_den[QUOTIENT_BITS]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en[QUOTIENT_BITS+1]) begin
            r_out_vld <= r_vld[QUOTIENT_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[QUOTIENT_BITS+1]) begin
            r_out_quo <= r_quo[QUOTIENT_BITS];
            r_out_rem <= r_rem[QUOTIENT_BITS];
            r_out_sat <= n_out_sat;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = OUT_W'({r_out_sat, r_out_rem, r_out_quo});

    `RDIV_ASSERT_NEXT(a_accept_fills, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, r_vld[0])
    `RDIV_ASSERT_SAME(a_last_rem_below, i_clk, i_rst_n, r_vld[QUOTIENT_BITS] && (r_den[QUOTIENT_BITS] != '0) && (r_quo[QUOTIENT_BITS] != QUO_ONES), SAT_W'(r_rem[QUOTIENT_BITS]) < SAT_W'(r_den[QUOTIENT_BITS]))
    `RDIV_ASSERT_SAME(a_sat_all_ones, i_clk, i_rst_n, r_out_vld && r_out_sat, r_out_quo == QUO_ONES)

endmodule

`default_nettype wire
